// File: rtl/core/glcp_pkg.sv
// Shared types and constants for the greedy leaf chunk planner.
// Used by the front stage, the item queue, the back stage and the top level.
package glcp_pkg;

  // Default widths for the top-level parameters.
  localparam int RecordIndexBitsDef = 32;
  localparam int TargetIndexBitsDef = 24;
  localparam int LeafCountBitsDef   = 12;

  // Pair sums are always this wide and saturate at the top value.
  localparam int PairBits = 48;

  // Budget value after reset.
  localparam logic [PairBits-1:0] PairBudgetReset = PairBits'(64'd1 << 22);

  // Depth of the queue between the front and the back stage.
  localparam int QueueDepth = 4;

  // Input command codes.
  localparam logic CmdRecord = 1'b0;
  localparam logic CmdEnd    = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_CHUNK     = 2'd0,
    STATUS_ORDER     = 2'd1,
    STATUS_OPEN_LEAF = 2'd2
  } status_e;

  // Decoded kind of one queued item.
  typedef struct packed {
    logic is_end;
    logic leaf_last;
  } item_flags_t;

  localparam int FlagBits = $bits(item_flags_t);

endpackage

// File: rtl/core/greedy_leaf_chunk_planner_unit.sv
// Top level of the greedy leaf chunk planner: front stage, queue, back stage.
// Depends on glcp_pkg, glcp_front, glcp_queue and glcp_back.
//
//   channel | direction | handshake                 | beat
//   --------+-----------+---------------------------+-------------------------------
//   in      | input     | in_valid_i / in_stall_o   | one record or end command
//   out     | output    | out_valid_o / out_stall_i | one chunk or error status
//   cfg     | input     | cfg_valid_i / cfg_ready_o | pair budget write
//
// One beat enters per cycle when nothing stalls, passing the front register, a
// queue entry and the output register on its way to a result. The back stage
// updates the list state for one beat a cycle while the output is not stalled; its
// critical path is the saturating leaf sum, then the chunk sum budget compare.
// Reset clears all list state and loads the default budget of 2^22 pairs.
// An output stall fills the four-entry queue, after which the input is stalled.
module greedy_leaf_chunk_planner_unit import glcp_pkg::*; #(
  parameter int RecordIndexBits = RecordIndexBitsDef,
  parameter int TargetIndexBits = TargetIndexBitsDef,
  parameter int LeafCountBits   = LeafCountBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       cmd_i,
  input  logic [TargetIndexBits-1:0] target_start_i,
  input  logic [LeafCountBits-1:0]   target_width_i,
  input  logic [LeafCountBits-1:0]   source_width_i,
  input  logic                       leaf_first_i,
  input  logic                       leaf_last_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [RecordIndexBits-1:0] chunk_record_begin_o,
  output logic [RecordIndexBits-1:0] chunk_record_end_o,
  output logic [TargetIndexBits-1:0] chunk_target_begin_o,
  output logic [TargetIndexBits:0]   chunk_target_end_o,
  output logic [PairBits-1:0]        chunk_pairs_o,
  output logic                       final_chunk_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [PairBits-1:0]        cfg_data_i
);

  localparam int EntryBits = FlagBits + TargetIndexBits + (TargetIndexBits + 1) +
                             2*LeafCountBits;

  item_flags_t                front_flags, back_flags;
  logic [TargetIndexBits-1:0] front_tstart, back_tstart;
  logic [TargetIndexBits:0]   front_tend, back_tend;
  logic [2*LeafCountBits-1:0] front_pairs, back_pairs;
  logic                       push, pop, queue_full, queue_empty;
  logic [EntryBits-1:0]       queue_wdata, queue_rdata;
  logic                       leaf_first_unused;

  // Leaf starts are tracked from the list state, so the first flag is not needed.
  assign leaf_first_unused = leaf_first_i;

  // The budget register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  glcp_front #(
    .TargetIndexBits(TargetIndexBits),
    .LeafCountBits  (LeafCountBits)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .target_start_i(target_start_i),
    .target_width_i(target_width_i),
    .source_width_i(source_width_i),
    .leaf_last_i   (leaf_last_i),
    .queue_full_i  (queue_full),
    .push_o        (push),
    .flags_o       (front_flags),
    .tstart_o      (front_tstart),
    .tend_o        (front_tend),
    .pairs_o       (front_pairs)
  );

  // Queue entry packing.
  assign queue_wdata = {front_flags, front_tstart, front_tend, front_pairs};
  assign {back_flags, back_tstart, back_tend, back_pairs} = queue_rdata;

  glcp_queue #(
    .Width(EntryBits)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (queue_wdata),
    .full_o (queue_full),
    .pop_i  (pop),
    .data_o (queue_rdata),
    .empty_o(queue_empty)
  );

  glcp_back #(
    .RecordIndexBits(RecordIndexBits),
    .TargetIndexBits(TargetIndexBits),
    .LeafCountBits  (LeafCountBits)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i & cfg_ready_o),
    .cfg_data_i          (cfg_data_i),
    .queue_empty_i       (queue_empty),
    .pop_o               (pop),
    .flags_i             (back_flags),
    .tstart_i            (back_tstart),
    .tend_i              (back_tend),
    .pairs_i             (back_pairs),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .chunk_record_begin_o(chunk_record_begin_o),
    .chunk_record_end_o  (chunk_record_end_o),
    .chunk_target_begin_o(chunk_target_begin_o),
    .chunk_target_end_o  (chunk_target_end_o),
    .chunk_pairs_o       (chunk_pairs_o),
    .final_chunk_o       (final_chunk_o)
  );

  // The back stage never takes a beat from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !queue_empty)
    else $error("back stage popped an empty queue");

  // The front stage never writes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !queue_full)
    else $error("front stage pushed into a full queue");

  // Error results carry no chunk contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && (status_o != STATUS_CHUNK)) |->
      ((chunk_pairs_o == '0) && (chunk_record_end_o == '0) && !leaf_first_unused
       || (chunk_pairs_o == '0) && (chunk_record_end_o == '0)))
    else $error("error result with nonzero chunk fields");

endmodule

// File: rtl/core/glcp_front.sv
// Front stage of the chunk planner: accepts input beats and classifies them.
// Computes the pair product and the leaf target end; depends on glcp_pkg.
module glcp_front import glcp_pkg::*; #(
  parameter int TargetIndexBits = TargetIndexBitsDef,
  parameter int LeafCountBits   = LeafCountBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       cmd_i,
  input  logic [TargetIndexBits-1:0] target_start_i,
  input  logic [LeafCountBits-1:0]   target_width_i,
  input  logic [LeafCountBits-1:0]   source_width_i,
  input  logic                       leaf_last_i,
  input  logic                       queue_full_i,
  output logic                       push_o,
  output item_flags_t                flags_o,
  output logic [TargetIndexBits-1:0] tstart_o,
  output logic [TargetIndexBits:0]   tend_o,
  output logic [2*LeafCountBits-1:0] pairs_o
);

  localparam int SumBits = ((TargetIndexBits > LeafCountBits) ?
                            TargetIndexBits : LeafCountBits) + 1;

  logic                       valid_q, valid_d;
  logic                       load;
  item_flags_t                flags_q;
  logic [TargetIndexBits-1:0] tstart_q;
  logic [TargetIndexBits:0]   tend_q;
  logic [2*LeafCountBits-1:0] pairs_q;
  logic [SumBits-1:0]         tend_sum;

  // The stage holds its beat while the queue is full.
  assign in_stall_o = valid_q & queue_full_i;
  assign load       = in_valid_i & ~in_stall_o;
  assign push_o     = valid_q & ~queue_full_i;
  assign valid_d    = in_stall_o ? valid_q : in_valid_i;

  // Target end of the leaf, wrapped to one bit above the target index.
  assign tend_sum = SumBits'(target_start_i) + SumBits'(target_width_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Stage payload: the product is registered before the back stage adds it.
  always_ff @(posedge clk_i) begin
    if (load) begin
      flags_q.is_end    <= (cmd_i == CmdEnd);
      flags_q.leaf_last <= leaf_last_i;
      tstart_q          <= target_start_i;
      tend_q            <= tend_sum[TargetIndexBits:0];
      pairs_q           <= (2*LeafCountBits)'(target_width_i) *
                           (2*LeafCountBits)'(source_width_i);
    end
  end

  assign flags_o  = flags_q;
  assign tstart_o = tstart_q;
  assign tend_o   = tend_q;
  assign pairs_o  = pairs_q;

endmodule

// File: rtl/core/glcp_queue.sv
// Short item queue between the front and the back stage of the planner.
// Plain register file with head and tail pointers; depends on glcp_pkg.
module glcp_queue import glcp_pkg::*; #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntBits = $clog2(QueueDepth + 1);

  logic [Width-1:0]   mem_q [QueueDepth];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] count_q;

  assign full_o  = (count_q == CntBits'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/core/glcp_back.sv
// Back stage of the planner: leaf accumulation, greedy chunk packing and errors.
// Holds the list state, the pair budget and the output register; uses glcp_pkg.
module glcp_back import glcp_pkg::*; #(
  parameter int RecordIndexBits = RecordIndexBitsDef,
  parameter int TargetIndexBits = TargetIndexBitsDef,
  parameter int LeafCountBits   = LeafCountBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic [PairBits-1:0]        cfg_data_i,
  input  logic                       queue_empty_i,
  output logic                       pop_o,
  input  item_flags_t                flags_i,
  input  logic [TargetIndexBits-1:0] tstart_i,
  input  logic [TargetIndexBits:0]   tend_i,
  input  logic [2*LeafCountBits-1:0] pairs_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [RecordIndexBits-1:0] chunk_record_begin_o,
  output logic [RecordIndexBits-1:0] chunk_record_end_o,
  output logic [TargetIndexBits-1:0] chunk_target_begin_o,
  output logic [TargetIndexBits:0]   chunk_target_end_o,
  output logic [PairBits-1:0]        chunk_pairs_o,
  output logic                       final_chunk_o
);

  logic [PairBits-1:0] budget_q;

  // List state.
  logic [RecordIndexBits-1:0] record_counter_q, record_counter_d;
  logic [RecordIndexBits-1:0] leaf_record_start_q, leaf_record_start_d;
  logic [PairBits-1:0]        leaf_pair_sum_q, leaf_pair_sum_d;
  logic [TargetIndexBits-1:0] leaf_target_lo_q, leaf_target_lo_d;
  logic [TargetIndexBits:0]   leaf_target_hi_q, leaf_target_hi_d;
  logic [TargetIndexBits:0]   prior_target_hi_q, prior_target_hi_d;
  logic                       chunk_open_q, chunk_open_d;
  logic [RecordIndexBits-1:0] open_record_start_q, open_record_start_d;
  logic [TargetIndexBits-1:0] open_target_lo_q, open_target_lo_d;
  logic [PairBits-1:0]        open_pair_sum_q, open_pair_sum_d;
  logic                       inside_leaf_q, inside_leaf_d;
  logic                       halted_q, halted_d;

  // Output register.
  logic                       out_valid_q, out_valid_d;
  status_e                    res_status_q, res_status_d;
  logic [RecordIndexBits-1:0] res_rb_q, res_rb_d, res_re_q, res_re_d;
  logic [TargetIndexBits-1:0] res_tb_q, res_tb_d;
  logic [TargetIndexBits:0]   res_te_q, res_te_d;
  logic [PairBits-1:0]        res_pairs_q, res_pairs_d;
  logic                       res_final_q, res_final_d;
  logic                       emit;

  // Work values for the current beat.
  logic                       leaf_start;
  logic [RecordIndexBits-1:0] cur_record_start;
  logic [TargetIndexBits-1:0] cur_target_lo;
  logic [TargetIndexBits:0]   cur_target_hi;
  logic [PairBits-1:0]        cur_base;
  logic [PairBits:0]          leaf_sum_wide;
  logic [PairBits-1:0]        leaf_sum;
  logic [PairBits:0]          open_sum_wide;
  logic [PairBits-1:0]        open_sum_sat;
  logic                       over_budget;

  // The back stage takes a beat whenever the output register is free or leaving.
  assign pop_o = ~queue_empty_i & (~out_valid_q | ~out_stall_i);

  // Leaf context: a record outside a leaf always opens one.
  assign leaf_start       = ~inside_leaf_q;
  assign cur_record_start = leaf_start ? record_counter_q : leaf_record_start_q;
  assign cur_target_lo    = leaf_start ? tstart_i : leaf_target_lo_q;
  assign cur_target_hi    = leaf_start ? tend_i : leaf_target_hi_q;
  assign cur_base         = leaf_start ? '0 : leaf_pair_sum_q;

  // Saturating leaf sum, then the open chunk sum with this leaf added.
  assign leaf_sum_wide = {1'b0, cur_base} + (PairBits+1)'(pairs_i);
  assign leaf_sum      = leaf_sum_wide[PairBits] ? '1 : leaf_sum_wide[PairBits-1:0];
  assign open_sum_wide = {1'b0, open_pair_sum_q} + {1'b0, leaf_sum};
  assign open_sum_sat  = open_sum_wide[PairBits] ? '1 : open_sum_wide[PairBits-1:0];
  assign over_budget   = chunk_open_q & (open_sum_wide > {1'b0, budget_q});

  // Next-state and result decode.
  always_comb begin
    record_counter_d    = record_counter_q;
    leaf_record_start_d = leaf_record_start_q;
    leaf_pair_sum_d     = leaf_pair_sum_q;
    leaf_target_lo_d    = leaf_target_lo_q;
    leaf_target_hi_d    = leaf_target_hi_q;
    prior_target_hi_d   = prior_target_hi_q;
    chunk_open_d        = chunk_open_q;
    open_record_start_d = open_record_start_q;
    open_target_lo_d    = open_target_lo_q;
    open_pair_sum_d     = open_pair_sum_q;
    inside_leaf_d       = inside_leaf_q;
    halted_d            = halted_q;
    emit                = 1'b0;
    res_status_d        = STATUS_CHUNK;
    res_rb_d            = '0;
    res_re_d            = '0;
    res_tb_d            = '0;
    res_te_d            = '0;
    res_pairs_d         = '0;
    res_final_d         = 1'b0;

    if (pop_o) begin
      if (flags_i.is_end) begin
        // End of list: unless halted, report an open leaf or the last chunk; then clear.
        if (!halted_q && inside_leaf_q) begin
          emit         = 1'b1;
          res_status_d = STATUS_OPEN_LEAF;
          res_final_d  = 1'b1;
        end else if (!halted_q && chunk_open_q) begin
          emit        = 1'b1;
          res_rb_d    = open_record_start_q;
          res_re_d    = record_counter_q;
          res_tb_d    = open_target_lo_q;
          res_te_d    = prior_target_hi_q;
          res_pairs_d = open_pair_sum_q;
          res_final_d = 1'b1;
        end
        record_counter_d    = '0;
        leaf_record_start_d = '0;
        leaf_pair_sum_d     = '0;
        leaf_target_lo_d    = '0;
        leaf_target_hi_d    = '0;
        prior_target_hi_d   = '0;
        chunk_open_d        = 1'b0;
        open_record_start_d = '0;
        open_target_lo_d    = '0;
        open_pair_sum_d     = '0;
        inside_leaf_d       = 1'b0;
        halted_d            = 1'b0;
      end else if (!halted_q) begin
        if (leaf_start && ({1'b0, tstart_i} < prior_target_hi_q)) begin
          // A new leaf starts below the end of the previous one.
          emit         = 1'b1;
          res_status_d = STATUS_ORDER;
          halted_d     = 1'b1;
        end else begin
          leaf_record_start_d = cur_record_start;
          leaf_target_lo_d    = cur_target_lo;
          leaf_target_hi_d    = cur_target_hi;
          leaf_pair_sum_d     = leaf_sum;
          record_counter_d    = record_counter_q + 1'b1;
          inside_leaf_d       = ~flags_i.leaf_last;
          if (flags_i.leaf_last) begin
            // Leaf complete: close the open chunk if this leaf does not fit.
            if (over_budget) begin
              emit        = 1'b1;
              res_rb_d    = open_record_start_q;
              res_re_d    = cur_record_start;
              res_tb_d    = open_target_lo_q;
              res_te_d    = prior_target_hi_q;
              res_pairs_d = open_pair_sum_q;
            end
            if (over_budget || !chunk_open_q) begin
              open_record_start_d = cur_record_start;
              open_target_lo_d    = cur_target_lo;
              open_pair_sum_d     = leaf_sum;
            end else begin
              open_pair_sum_d = open_sum_sat;
            end
            chunk_open_d      = 1'b1;
            prior_target_hi_d = cur_target_hi;
          end
        end
      end
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control and list state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q            <= PairBudgetReset;
      record_counter_q    <= '0;
      leaf_record_start_q <= '0;
      leaf_pair_sum_q     <= '0;
      leaf_target_lo_q    <= '0;
      leaf_target_hi_q    <= '0;
      prior_target_hi_q   <= '0;
      chunk_open_q        <= 1'b0;
      open_record_start_q <= '0;
      open_target_lo_q    <= '0;
      open_pair_sum_q     <= '0;
      inside_leaf_q       <= 1'b0;
      halted_q            <= 1'b0;
      out_valid_q         <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        budget_q <= cfg_data_i;
      end
      record_counter_q    <= record_counter_d;
      leaf_record_start_q <= leaf_record_start_d;
      leaf_pair_sum_q     <= leaf_pair_sum_d;
      leaf_target_lo_q    <= leaf_target_lo_d;
      leaf_target_hi_q    <= leaf_target_hi_d;
      prior_target_hi_q   <= prior_target_hi_d;
      chunk_open_q        <= chunk_open_d;
      open_record_start_q <= open_record_start_d;
      open_target_lo_q    <= open_target_lo_d;
      open_pair_sum_q     <= open_pair_sum_d;
      inside_leaf_q       <= inside_leaf_d;
      halted_q            <= halted_d;
      out_valid_q         <= out_valid_d;
    end
  end

  // Result payload, loaded only with a new beat.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_status_q <= res_status_d;
      res_rb_q     <= res_rb_d;
      res_re_q     <= res_re_d;
      res_tb_q     <= res_tb_d;
      res_te_q     <= res_te_d;
      res_pairs_q  <= res_pairs_d;
      res_final_q  <= res_final_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = res_status_q;
  assign chunk_record_begin_o = res_rb_q;
  assign chunk_record_end_o   = res_re_q;
  assign chunk_target_begin_o = res_tb_q;
  assign chunk_target_end_o   = res_te_q;
  assign chunk_pairs_o        = res_pairs_q;
  assign final_chunk_o        = res_final_q;

endmodule
